### hdl/pre_pkg.sv
// Shared constants and types for the phasing rate estimator.
`timescale 1ns / 1ps

package pre_pkg;

    localparam int CH        = 4;
    localparam int CH_W      = $clog2(CH);
    localparam int IN_W      = 16;
    localparam int SUM_W     = 32;
    localparam int CNT_W     = 17;
    localparam int FRAC_W    = 8;
    localparam int MEAN_W    = IN_W + FRAC_W;
    localparam int DIVD_W    = SUM_W + FRAC_W;
    localparam int EST_W     = 25;
    localparam int D_W       = MEAN_W + 3;
    localparam int DIV_STEPS = DIVD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int SEQ_W     = CH_W + 1;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [MEAN_W-1:0] MEAN_MAX = {{IN_W{1'b1}}, {FRAC_W{1'b0}}};

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### hdl/pre_div.sv
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module pre_div
    import pre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic [DIVD_W-1:0] quotient,
    output div_status_t       status
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     rem_next;
    logic [DIVD_W-1:0]    quo_reg;
    logic [DIVD_W-1:0]    quo_next;
    logic [CNT_W-1:0]     dsr_reg;
    logic [CNT_W:0]       shifted;
    logic [CNT_W:0]       diff;
    logic                 take;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVD_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        take    = shifted >= {1'b0, dsr_reg};
        // The partial remainder stays below the divisor, so it fits CNT_W bits.
        rem_next = take ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        quo_next = {quo_reg[DIVD_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### hdl/phasing_rate_estimator.sv
// Top level of the phasing rate estimator: accumulators, sequencer and stream ports.
// An item with tlast low is folded into the accumulators; such items are taken every
// cycle while the block is in its idle state. An item with tlast high is folded in, then
// the eight channel means go one after another through the shared divider (a mean with
// a zero count skips it); no input item is taken meanwhile. The asynchronous reset
// clears mode and all accumulators at once; no clearing pass is needed.
`timescale 1ns / 1ps

module phasing_rate_estimator
    import pre_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // current_ch0, current_ch1, current_ch2, current_ch3,
    // neighbour_ch0, neighbour_ch1, neighbour_ch2, neighbour_ch3
    input  logic [127:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // estimate, zero padding above
    output logic [31:0]  m_tdata
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_START  = 4'b0010,
        S_WAIT   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic                           mode_reg;
    logic [CH-1:0][SUM_W-1:0]       lag_sum_reg;
    logic [CH-1:0][SUM_W-1:0]       lag_sum_next;
    logic [CH-1:0][CNT_W-1:0]       lag_count_reg;
    logic [CH-1:0][CNT_W-1:0]       lag_count_next;
    logic [CH-1:0][SUM_W-1:0]       background_sum_reg;
    logic [CH-1:0][SUM_W-1:0]       background_sum_next;
    logic [CH-1:0][CNT_W-1:0]       background_count_reg;
    logic [CH-1:0][CNT_W-1:0]       background_count_next;
    logic [SEQ_W-1:0]               seq_reg;
    logic [SEQ_W-1:0]               seq_next;
    logic signed [D_W-1:0]          d_reg;
    logic signed [D_W-1:0]          d_next;
    logic                           m_tvalid_reg;
    logic [EST_W-1:0]               m_est_reg;

    logic [CH-1:0][IN_W-1:0]        cur;
    logic [CH-1:0][IN_W-1:0]        nb;
    logic [CH_W-1:0]                cur_base;
    logic [CH_W-1:0]                nb_base;
    logic                           in_acc;
    logic                           out_load;
    logic                           clear_acc;
    logic [CH_W-1:0]                sel_ch;
    logic                           sel_bg;
    logic [SUM_W-1:0]               sel_sum;
    logic [CNT_W-1:0]               sel_cnt;
    logic                           div_start;
    logic [DIVD_W-1:0]              div_dividend;
    logic [CNT_W-1:0]               div_divisor;
    logic [DIVD_W-1:0]              div_quotient;
    div_status_t                    div_status;
    logic [MEAN_W-1:0]              mean;
    logic signed [D_W-1:0]          mean_s;
    logic signed [D_W-1:0]          d_round;

    function automatic logic [CH_W-1:0] pick_max(input logic [CH-1:0][IN_W-1:0] x);
        logic [CH_W-1:0] best;
        best = '0;
        for (int k = 1; k < CH; k++)
        begin
            if (x[k] > x[best])
            begin
                best = CH_W'(k);
            end
        end
        return best;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [IN_W-1:0]  v);
        logic [SUM_W:0] t;
        t = {1'b0, s} + {{(SUM_W + 1 - IN_W){1'b0}}, v};
        return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    always_comb
    begin
        for (int k = 0; k < CH; k++)
        begin
            cur[k] = s_tdata[k*IN_W +: IN_W];
            nb[k]  = s_tdata[(CH + k)*IN_W +: IN_W];
        end
        cur_base = pick_max(cur);
        nb_base  = pick_max(nb);
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_load  = (state_reg == S_FINISH) && (!m_tvalid_reg || m_tready);
    assign clear_acc = out_load;

    always_comb
    begin
        lag_sum_next          = lag_sum_reg;
        lag_count_next        = lag_count_reg;
        background_sum_next   = background_sum_reg;
        background_count_next = background_count_reg;
        if (clear_acc)
        begin
            lag_sum_next          = '0;
            lag_count_next        = '0;
            background_sum_next   = '0;
            background_count_next = '0;
        end
        else if (in_acc)
        begin
            for (int k = 0; k < CH; k++)
            begin
                if ((cur_base != nb_base) && (CH_W'(k) == nb_base))
                begin
                    lag_sum_next[k]   = sat_add(lag_sum_reg[k], cur[k]);
                    lag_count_next[k] = sat_inc(lag_count_reg[k]);
                end
                if ((CH_W'(k) != cur_base) && (CH_W'(k) != nb_base))
                begin
                    background_sum_next[k]   = sat_add(background_sum_reg[k], cur[k]);
                    background_count_next[k] = sat_inc(background_count_reg[k]);
                end
            end
        end
    end

    // The sequence index walks the lag means first, then the background means.
    assign sel_ch  = seq_reg[CH_W-1:0];
    assign sel_bg  = seq_reg[SEQ_W-1];
    assign sel_sum = sel_bg ? background_sum_reg[sel_ch] : lag_sum_reg[sel_ch];
    assign sel_cnt = sel_bg ? background_count_reg[sel_ch] : lag_count_reg[sel_ch];

    assign div_dividend = {sel_sum, {FRAC_W{1'b0}}};
    assign div_divisor  = sel_cnt;

    assign mean   = (div_quotient > {{(DIVD_W - MEAN_W){1'b0}}, MEAN_MAX})
                    ? MEAN_MAX : div_quotient[MEAN_W-1:0];
    assign mean_s = $signed({{(D_W - MEAN_W){1'b0}}, mean});

    always_comb
    begin
        state_next = state_reg;
        seq_next   = seq_reg;
        d_next     = d_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && s_tlast)
                begin
                    state_next = S_START;
                    seq_next   = '0;
                    d_next     = '0;
                end
            end
            S_START:
            begin
                if (sel_cnt != '0)
                begin
                    div_start  = 1'b1;
                    state_next = S_WAIT;
                end
                else if (seq_reg == {SEQ_W{1'b1}})
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    seq_next = seq_reg + 1'b1;
                end
            end
            S_WAIT:
            begin
                if (div_status.done)
                begin
                    d_next = sel_bg ? d_reg - mean_s : d_reg + mean_s;
                    if (seq_reg == {SEQ_W{1'b1}})
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        seq_next   = seq_reg + 1'b1;
                        state_next = S_START;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Adding two and shifting right by two rounds to nearest, ties upward.
    assign d_round = d_reg + D_W'(2);

    pre_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            mode_reg             <= 1'b0;
            lag_sum_reg          <= '0;
            lag_count_reg        <= '0;
            background_sum_reg   <= '0;
            background_count_reg <= '0;
            seq_reg              <= '0;
            m_tvalid_reg         <= 1'b0;
        end
        else
        begin
            state_reg            <= state_next;
            lag_sum_reg          <= lag_sum_next;
            lag_count_reg        <= lag_count_next;
            background_sum_reg   <= background_sum_next;
            background_count_reg <= background_count_next;
            seq_reg              <= seq_next;
            // The mode does not alter the math.
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
        if (out_load)
        begin
            m_est_reg <= d_round[D_W-1:2];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(32 - EST_W){1'b0}}, m_est_reg};

    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (lag_count_reg == '0) && (background_count_reg == '0)
                     && (lag_sum_reg == '0) && (background_sum_reg == '0))
        else $error("accumulators not cleared after a result");

    a_no_zero_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (div_divisor != '0))
        else $error("divider started with an empty count");

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_status.busy && !div_status.done)
        else $error("divider active while the block takes items");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == S_WAIT))
        else $error("divider finished outside the wait state");

    a_mode_held_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) && !cfg_we |=> $stable(mode_reg))
        else $error("mode changed without a write");

endmodule
